// ===== src/bpar_pkg.sv =====
// Package for the BLE private address resolver: item types, AES S-box,
// round constants and the AES round and key schedule functions.
// No dependencies.
package bpar_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned AES_ROUNDS  = 10;
    localparam int unsigned KEY_W       = 128;
    localparam int unsigned BLOCK_BYTES = 16;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 64;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_IRK_LOW  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IRK_HIGH = 1'b1;

    // One classified address: random part and received hash.
    typedef struct packed {
        logic [23:0] prand;
        logic [23:0] hash;
    } bpar_item_t;

    // Head of the queue as seen by the back part.
    typedef struct packed {
        logic       valid;
        bpar_item_t item;
    } bpar_head_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Round constants for the key schedule, first round first.
    localparam logic [7:0] RCON [AES_ROUNDS] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] xtime(logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block sits in bits 127-8i down to 120-8i.
    function automatic logic [7:0] get_byte(logic [KEY_W-1:0] blk, int unsigned i);
        return blk[KEY_W-1-8*i -: 8];
    endfunction

    // Next round key from the previous one.
    function automatic logic [KEY_W-1:0] next_key(logic [KEY_W-1:0] rk, logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = rk[127:96];
        w1 = rk[95:64];
        w2 = rk[63:32];
        w3 = rk[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // One AES round: SubBytes, ShiftRows, MixColumns unless last, AddRoundKey.
    function automatic logic [KEY_W-1:0] aes_round(logic [KEY_W-1:0] s,
                                                   logic [KEY_W-1:0] rk,
                                                   logic last);
        logic [7:0] t [BLOCK_BYTES];
        logic [7:0] a0, a1, a2, a3, all;
        logic [KEY_W-1:0] res;
        for (int unsigned c = 0; c < 4; c++) begin
            for (int unsigned r = 0; r < 4; r++) begin
                t[r + 4*c] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
            end
        end
        if (!last) begin
            for (int unsigned c = 0; c < 4; c++) begin
                a0  = t[4*c];
                a1  = t[4*c + 1];
                a2  = t[4*c + 2];
                a3  = t[4*c + 3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]     = a0 ^ all ^ xtime(a0 ^ a1);
                t[4*c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
                t[4*c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
                t[4*c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        for (int unsigned i = 0; i < BLOCK_BYTES; i++) begin
            res[KEY_W-1-8*i -: 8] = t[i] ^ get_byte(rk, i);
        end
        return res;
    endfunction

endpackage

// ===== src/bpar_if.sv =====
// Channel interfaces of the resolver: address items in, resolution items out.
// Depends on nothing.
interface bpar_addr_if;
    logic        valid;
    logic        ready;
    logic [47:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface bpar_res_if;
    logic        valid;
    logic        ready;
    logic        match;
    logic [23:0] computed_hash;

    modport source (output valid, output match, output computed_hash, input ready);
    modport sink   (input valid, input match, input computed_hash, output ready);
endinterface

// ===== src/bpar_front.sv =====
// Front part: accepts address items, splits them into random part and hash,
// and holds them in a short queue for the AES pipeline. Uses bpar_pkg.
module bpar_front
    import bpar_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    bpar_addr_if.sink  addr_ch,
    output bpar_head_t head,
    input  logic       pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bpar_item_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;

    assign addr_ch.ready = (count_reg != FULL_CNT);
    assign push          = addr_ch.valid && addr_ch.ready;
    assign head.valid    = (count_reg != '0);
    assign head.item     = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Classify the address into its random part and its hash.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg].prand <= addr_ch.address[47:24];
            slot_reg[wr_ptr_reg].hash  <= addr_ch.address[23:0];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue fill count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("queue popped while empty");

endmodule

// ===== src/bpar_back.sv =====
// Back part: eleven-stage AES-128 pipeline with the key schedule carried
// alongside each item; the last stage is the output register. Uses bpar_pkg.
module bpar_back
    import bpar_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [KEY_W-1:0] key,
    input  bpar_head_t       head,
    output logic             pop,
    bpar_res_if.source       res_ch
);

    logic             vld_reg  [AES_ROUNDS+1];
    logic [KEY_W-1:0] st_reg   [AES_ROUNDS+1];
    logic [KEY_W-1:0] rk_reg   [AES_ROUNDS];
    logic [23:0]      hash_reg [AES_ROUNDS];
    logic             match_reg;
    logic [KEY_W-1:0] st_next  [AES_ROUNDS+1];
    logic [KEY_W-1:0] rk_next  [AES_ROUNDS+1];
    logic             advance;

    // The whole pipeline moves unless the output register is held.
    assign advance = !vld_reg[AES_ROUNDS] || res_ch.ready;
    assign pop     = advance && head.valid;

    assign res_ch.valid         = vld_reg[AES_ROUNDS];
    assign res_ch.match         = match_reg;
    assign res_ch.computed_hash = st_reg[AES_ROUNDS][23:0];

    // Initial key addition and one round per following stage.
    always_comb
    begin
        rk_next[0] = key;
        st_next[0] = {104'b0, head.item.prand} ^ key;
        for (int unsigned k = 1; k <= AES_ROUNDS; k++)
        begin
            rk_next[k] = next_key(rk_reg[k-1], RCON[k-1]);
            st_next[k] = aes_round(st_reg[k-1], rk_next[k], k == AES_ROUNDS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int unsigned k = 0; k <= AES_ROUNDS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= head.valid;
            for (int unsigned k = 1; k <= AES_ROUNDS; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Payload of every stage, hash compare in the last.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st_reg[0]   <= st_next[0];
            rk_reg[0]   <= rk_next[0];
            hash_reg[0] <= head.item.hash;
            for (int unsigned k = 1; k <= AES_ROUNDS; k++)
            begin
                st_reg[k] <= st_next[k];
            end
            for (int unsigned k = 1; k < AES_ROUNDS; k++)
            begin
                rk_reg[k]   <= rk_next[k];
                hash_reg[k] <= hash_reg[k-1];
            end
            match_reg <= (st_next[AES_ROUNDS][23:0] == hash_reg[AES_ROUNDS-1]);
        end
    end

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ch.valid && !res_ch.ready) |=> (res_ch.valid && $stable(match_reg)
            && $stable(st_reg[AES_ROUNDS][23:0])))
        else $error("held result changed under stall");

    a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ch.valid && !res_ch.ready) |-> !pop)
        else $error("queue popped while pipeline stalled");

endmodule

// ===== src/ble_private_address_resolver.sv =====
// Path: an accepted address item waits in the queue, then passes key addition
// and ten AES rounds, one stage each.
// Throughput: one address per cycle unless the output is held; the fully unrolled
// round pipeline sets it. A held output stalls all stages; the two-entry queue
// keeps taking items until it is full. Reset (rst_n, asynchronous, active low)
// empties queue and pipeline and clears both identity key registers to zero.
module ble_private_address_resolver
    import bpar_pkg::*;
#(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    bpar_addr_if.sink              addr_ch,
    bpar_res_if.source             res_ch,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [63:0] irk_low_reg;
    logic [63:0] irk_high_reg;
    bpar_head_t  head;
    logic        pop;

    // Identity key registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irk_low_reg  <= '0;
            irk_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IRK_LOW:  irk_low_reg  <= cfg_data;
                REG_IRK_HIGH: irk_high_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    bpar_front #(.DEPTH(QDEPTH)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .addr_ch (addr_ch),
        .head    (head),
        .pop     (pop)
    );

    // The AES key is the high identity key register followed by the low one.
    bpar_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .key    ({irk_high_reg, irk_low_reg}),
        .head   (head),
        .pop    (pop),
        .res_ch (res_ch)
    );

endmodule

// ===== verif/tb.sv =====
// Testbench for the BLE private address resolver: random and directed addresses
// under several identity keys, with an independent AES-128 hash predictor.
// Depends on bpar_pkg and the channel interfaces in bpar_if.sv.
module tb;
    import bpar_pkg::*;

    typedef struct {
        logic        match;
        logic [23:0] computed_hash;
    } resolution_t;

    localparam int IDLE_PCT   = 11;
    localparam int HOLD_LEN   = 300;
    localparam int WDOG_LIMIT = 3000;
    localparam int PIPE_LAT   = 14;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bpar_addr_if addr_ch();
    bpar_res_if  res_ch();

    ble_private_address_resolver DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .addr_ch   (addr_ch.sink),
        .res_ch    (res_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [47:0]  pending_addrs[$];
    resolution_t  expected_res[$];
    logic [63:0]  irk_lo_copy;
    logic [63:0]  irk_hi_copy;
    int           accepted_cnt;
    int           hold_left;
    bit           hold_done;
    int           stall_cycles;
    int           errors;

    // Doubling in GF(2^8) with the AES polynomial.
    function automatic logic [7:0] gf_dbl(logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // AES-128 of 104 zero bits followed by the random part; returns the low 24 bits.
    function automatic logic [23:0] ah_hash(logic [127:0] aes_key, logic [23:0] prand);
        logic [7:0]   rk [176];
        logic [7:0]   st [16];
        logic [7:0]   sh [16];
        logic [7:0]   w [4];
        logic [7:0]   rc;
        logic [7:0]   f;
        logic [7:0]   a0, a1, a2, a3, x;
        logic [127:0] pt;
        pt = {104'b0, prand};
        rc = 8'h01;
        for (int i = 0; i < 16; i++)
        begin
            rk[i] = aes_key[127-8*i -: 8];
            st[i] = pt[127-8*i -: 8] ^ rk[i];
        end
        // Key schedule, one word at a time.
        for (int i = 16; i < 176; i += 4)
        begin
            for (int j = 0; j < 4; j++)
                w[j] = rk[i-4+j];
            if (i % 16 == 0)
            begin
                f    = w[0];
                w[0] = SBOX[w[1]] ^ rc;
                w[1] = SBOX[w[2]];
                w[2] = SBOX[w[3]];
                w[3] = SBOX[f];
                rc   = gf_dbl(rc);
            end
            for (int j = 0; j < 4; j++)
                rk[i+j] = rk[i-16+j] ^ w[j];
        end
        // Ten rounds; the last one skips the column mix.
        for (int rnd = 1; rnd <= 10; rnd++)
        begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    sh[r+4*c] = SBOX[st[r+4*((c+r)%4)]];
            if (rnd != 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = sh[4*c]; a1 = sh[4*c+1]; a2 = sh[4*c+2]; a3 = sh[4*c+3];
                    x  = a0 ^ a1 ^ a2 ^ a3;
                    sh[4*c]   = a0 ^ x ^ gf_dbl(a0 ^ a1);
                    sh[4*c+1] = a1 ^ x ^ gf_dbl(a1 ^ a2);
                    sh[4*c+2] = a2 ^ x ^ gf_dbl(a2 ^ a3);
                    sh[4*c+3] = a3 ^ x ^ gf_dbl(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
                st[i] = sh[i] ^ rk[16*rnd+i];
        end
        return {st[13], st[14], st[15]};
    endfunction

    // Expected resolution of one address under the current key.
    function automatic resolution_t resolve_addr(logic [47:0] a);
        resolution_t res;
        // AES key byte 0 is the top byte of the high key register.
        res.computed_hash = ah_hash({irk_hi_copy, irk_lo_copy}, a[47:24]);
        res.match         = (res.computed_hash == a[23:0]);
        return res;
    endfunction

    // Address that resolves under the current key, optionally with hash bits flipped.
    function automatic logic [47:0] resolvable_addr(logic [23:0] prand, logic [23:0] flip);
        return {prand, ah_hash({irk_hi_copy, irk_lo_copy}, prand) ^ flip};
    endfunction

    function automatic logic [47:0] random_addr();
        int kind;
        kind = $urandom_range(9);
        if (kind < 5)
            return resolvable_addr(24'($urandom), 24'h0);
        else if (kind < 7)
            return resolvable_addr(24'($urandom), 24'h1 << $urandom_range(23));
        else
            return 48'({$urandom, $urandom});
    endfunction

    function automatic int idle_pct();
        // No idling at all over a long stretch in the middle of the run.
        if (accepted_cnt >= 1000 && accepted_cnt < 1300)
            return 0;
        return IDLE_PCT;
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Address driver: offers pending items and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_ch.valid   <= 1'b0;
            addr_ch.address <= '0;
        end
        else
        begin
            if (addr_ch.valid && addr_ch.ready)
            begin
                expected_res.push_back(resolve_addr(addr_ch.address));
                accepted_cnt++;
            end
            if (!addr_ch.valid || addr_ch.ready)
            begin
                if (pending_addrs.size() > 0 && $urandom_range(99) >= idle_pct())
                begin
                    addr_ch.valid   <= 1'b1;
                    addr_ch.address <= pending_addrs.pop_front();
                end
                else
                    addr_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each accepted item and drives ready with stalls.
    always @(posedge clk or negedge rst_n)
    begin
        resolution_t exp_res;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_res.size() == 0)
                begin
                    $display("%0t: unexpected result match=%0b hash=%h", $time,
                             res_ch.match, res_ch.computed_hash);
                    errors++;
                end
                else
                begin
                    exp_res = expected_res.pop_front();
                    if (res_ch.match !== exp_res.match)
                    begin
                        $display("%0t: match expected %0b actual %0b", $time,
                                 exp_res.match, res_ch.match);
                        errors++;
                    end
                    if (res_ch.computed_hash !== exp_res.computed_hash)
                    begin
                        $display("%0t: computed_hash expected %h actual %h", $time,
                                 exp_res.computed_hash, res_ch.computed_hash);
                        errors++;
                    end
                end
            end
            // One long hold-off so the pipeline fills and input stalls.
            if (!hold_done && accepted_cnt >= 600)
            begin
                hold_done    = 1'b1;
                hold_left    = HOLD_LEN;
                res_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= idle_pct());
        end
    end

    // Watchdog on cycles with no progress on either channel.
    always @(posedge clk)
    begin
        if ((addr_ch.valid && addr_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Waits until every item is through and the pipeline has emptied.
    task automatic drain();
        while (pending_addrs.size() > 0 || addr_ch.valid || expected_res.size() > 0)
            @(posedge clk);
        repeat (PIPE_LAT) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_IRK_LOW)
            irk_lo_copy = value;
        else
            irk_hi_copy = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            pending_addrs.push_back(random_addr());
        drain();
    endtask

    // Stimulus sequence.
    initial
    begin
        errors       = 0;
        accepted_cnt = 0;
        stall_cycles = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        irk_lo_copy  = '0;
        irk_hi_copy  = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_IRK_LOW;
        cfg_data     = '0;
        rst_n        = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items under the reset key: field extremes, hits and near misses.
        pending_addrs.push_back(48'h0);
        pending_addrs.push_back(48'hffff_ffff_ffff);
        pending_addrs.push_back(48'haaaa_aaaa_aaaa);
        pending_addrs.push_back(48'h5555_5555_5555);
        pending_addrs.push_back(resolvable_addr(24'h000000, 24'h0));
        pending_addrs.push_back(resolvable_addr(24'hffffff, 24'h0));
        pending_addrs.push_back(resolvable_addr(24'h800001, 24'h0));
        pending_addrs.push_back(resolvable_addr(24'h400000, 24'h000001));
        pending_addrs.push_back(resolvable_addr(24'h123456, 24'h800000));
        pending_addrs.push_back({24'h0, 24'hffffff});
        pending_addrs.push_back({24'hffffff, 24'h0});
        drain();
        random_phase(300);

        // All-ones key.
        write_reg(REG_IRK_LOW, 64'hffff_ffff_ffff_ffff);
        write_reg(REG_IRK_HIGH, 64'hffff_ffff_ffff_ffff);
        pending_addrs.push_back(resolvable_addr(24'h0, 24'h0));
        pending_addrs.push_back(48'hffff_ffff_ffff);
        random_phase(400);

        // Random key.
        write_reg(REG_IRK_LOW, {$urandom, $urandom});
        write_reg(REG_IRK_HIGH, {$urandom, $urandom});
        random_phase(500);

        // Only one half of the key set, then the other.
        write_reg(REG_IRK_HIGH, 64'h0);
        random_phase(300);
        write_reg(REG_IRK_LOW, 64'h0);
        write_reg(REG_IRK_HIGH, {$urandom, $urandom});
        random_phase(340);

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== ble_private_address_resolver.f =====
src/bpar_pkg.sv
src/bpar_if.sv
src/bpar_front.sv
src/bpar_back.sv
src/ble_private_address_resolver.sv
verif/tb.sv
